// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the majority filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bmmf_pkg.sv =====
// Shared types and constants of the binary mask majority filter.
`default_nettype none

package bmmf_pkg;

  localparam int MaxWidth      = 2048;
  localparam int MaxHeight     = 4096;
  localparam int MajorityLimit = 4;

  localparam int XW      = $clog2(MaxWidth);
  localparam int YW      = $clog2(MaxHeight);
  localparam int CfgWW   = XW + 1;
  localparam int CfgHW   = YW + 1;
  localparam int CfgDataW = (CfgWW > CfgHW) ? CfgWW : CfgHW;

  localparam int FifoDepth = 3;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  // Pixel in the window stage
  typedef struct packed {
    logic          valid;
    logic          mask_bit;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } pix_t;

  // Filtered pixel
  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          filtered_bit;
  } res_t;

  // Line store write-back
  typedef struct packed {
    logic          we;
    logic [XW-1:0] addr;
    logic [1:0]    data;
  } ls_wr_t;

  // Result queue status
  typedef struct packed {
    logic [FifoCntW-1:0] count;
    logic                empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmmf_line_store.sv =====
// Two row line stores packed in one memory, with write-to-read forwarding.
`default_nettype none

module bmmf_line_store (
  input  wire logic                 clk_i,
  input  wire logic [bmmf_pkg::XW-1:0] raddr_i,
  input  wire bmmf_pkg::ls_wr_t     wr_i,
  output logic [1:0]                rdata_o
);
  import bmmf_pkg::*;

  // Bit 1 holds row y-1, bit 0 holds row y-2
  logic [1:0] mem_q [MaxWidth];
  logic [1:0] rd_q;
  logic [1:0] fwd_q;
  logic       hit_q;

  // Write back the shifted column
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read every cycle; capture a same-address write of this edge
  always_ff @(posedge clk_i) begin
    rd_q  <= mem_q[raddr_i];
    fwd_q <= wr_i.data;
    hit_q <= wr_i.we && (wr_i.addr == raddr_i);
  end

  assign rdata_o = hit_q ? fwd_q : rd_q;

endmodule

`default_nettype wire

// ===== rtl/core/bmmf_window.sv =====
// 3x3 window shift register, border test and majority vote.
`default_nettype none

module bmmf_window (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bmmf_pkg::pix_t           pix_i,
  input  wire logic [1:0]               rows_i,
  input  wire logic [bmmf_pkg::CfgWW-1:0] width_i,
  input  wire logic [bmmf_pkg::CfgHW-1:0] height_i,
  output bmmf_pkg::ls_wr_t              wr_o,
  output logic                          push_o,
  output bmmf_pkg::res_t                res_o
);
  import bmmf_pkg::*;

  logic [8:0] window_q;
  logic [8:0] window_d;
  logic [2:0] col;
  logic [3:0] ones;
  logic       border;

  // New column: bit 0 row y-2, bit 1 row y-1, bit 2 row y
  assign col      = {pix_i.mask_bit, rows_i[1], rows_i[0]};
  assign window_d = {col, window_q[8:3]};

  // Advance the window on each pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (pix_i.valid) begin
      window_q <= window_d;
    end
  end

  // Count set bits of the updated window
  always_comb begin
    ones = '0;
    for (int i = 0; i < 9; i++) begin
      ones = ones + 4'(window_d[i]);
    end
  end

  // Center is (x-1,y-1); border covers first and last row and column
  assign border = (pix_i.x == XW'(1)) || (pix_i.y == YW'(1))
               || ({1'b0, pix_i.x} >= width_i) || ({1'b0, pix_i.y} >= height_i);

  assign push_o             = pix_i.valid && (pix_i.x != '0) && (pix_i.y != '0);
  assign res_o.x            = pix_i.x - XW'(1);
  assign res_o.y            = pix_i.y - YW'(1);
  assign res_o.filtered_bit = !border && (ones > 4'(MajorityLimit));

  // Shift the column down one row in the line store
  assign wr_o.we   = pix_i.valid;
  assign wr_o.addr = pix_i.x;
  assign wr_o.data = {pix_i.mask_bit, rows_i[1]};

endmodule

`default_nettype wire

// ===== rtl/core/bmmf_out_fifo.sv =====
// Result queue between the filter pipeline and the output channel.
`default_nettype none

module bmmf_out_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bmmf_pkg::res_t data_i,
  input  wire logic           pop_i,
  output bmmf_pkg::res_t      head_o,
  output bmmf_pkg::fifo_stat_t stat_o
);
  import bmmf_pkg::*;

  res_t                fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoCntW-1:0] count_q;

  function automatic logic [FifoPtrW-1:0] ptr_inc(input logic [FifoPtrW-1:0] p);
    ptr_inc = (p == FifoPtrW'(FifoDepth - 1)) ? '0 : p + FifoPtrW'(1);
  endfunction

  // Store the pushed result
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FifoCntW'(1);
      end
    end
  end

  assign head_o       = fifo_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/binary_mask_majority_filter_3x3_unit.sv =====
// Top level of the streaming 3x3 majority filter for binary masks.
// Takes one mask pixel per clock in raster order and returns the majority
// result of the pixel one column left and one row up, with its coordinates,
// once x>=1 and y>=1; the last column and row are not returned. The two
// previous rows live in a 2048 x 2-bit memory read at the pixel's column on
// acceptance and written back in the next cycle, so a pixel can enter every
// clock. A three-entry result queue lets input continue while results wait;
// input stalls only when three results are queued or in flight. The user
// must write frame width and height through the configuration port only
// while the block is idle, which the block does not enforce. A width keeps
// its low 12 bits; out-of-range values then act as the nearest valid size.
`default_nettype none
`include "assert_macros.svh"

module binary_mask_majority_filter_3x3_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration
  input  wire logic                         cfg_we_i,
  input  wire bmmf_pkg::cfg_idx_e           cfg_idx_i,
  input  wire logic [bmmf_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Pixel input
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         mask_bit_i,
  input  wire logic                         frame_start_i,
  // Result output
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [bmmf_pkg::XW-1:0]           out_x_o,
  output logic [bmmf_pkg::YW-1:0]           out_y_o,
  output logic                              filtered_bit_o
);
  import bmmf_pkg::*;

  logic [CfgWW-1:0] frame_width_q;
  logic [CfgHW-1:0] frame_height_q;
  logic [CfgWW-1:0] width_eff;
  logic [CfgHW-1:0] height_eff;

  logic [XW-1:0] x_q, x_d, x_cur;
  logic [YW-1:0] y_q, y_d, y_cur;
  logic          in_accept;
  pix_t          pix_q, pix_d;

  logic [1:0]    rows;
  ls_wr_t        ls_wr;
  logic          push;
  res_t          res;
  res_t          head;
  fifo_stat_t    fifo_stat;
  logic          pop;
  logic [FifoCntW:0] inflight;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgWW'(640);
      frame_height_q <= CfgHW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFrameWidth:  frame_width_q  <= cfg_wdata_i[CfgWW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_wdata_i[CfgHW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate frame size to the supported range
  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = CfgWW'(1);
    end else if (frame_width_q > CfgWW'(MaxWidth)) begin
      width_eff = CfgWW'(MaxWidth);
    end else begin
      width_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      height_eff = CfgHW'(1);
    end else if (frame_height_q > CfgHW'(MaxHeight)) begin
      height_eff = CfgHW'(MaxHeight);
    end else begin
      height_eff = frame_height_q;
    end
  end

  // Throttle input on results queued plus the one in flight
  assign inflight   = {1'b0, fifo_stat.count} + (FifoCntW + 1)'(pix_q.valid);
  assign in_stall_o = (inflight >= (FifoCntW + 1)'(FifoDepth));
  assign in_accept  = in_valid_i && !in_stall_o;

  // Locate the pixel and advance the raster position
  always_comb begin
    x_cur = frame_start_i ? '0 : x_q;
    y_cur = frame_start_i ? '0 : y_q;
    x_d   = x_cur + XW'(1);
    y_d   = y_cur;
    if (({1'b0, x_cur} + CfgWW'(1)) >= width_eff) begin
      x_d = '0;
      if (({1'b0, y_cur} + CfgHW'(1)) >= height_eff) begin
        y_d = '0;
      end else begin
        y_d = y_cur + YW'(1);
      end
    end
    pix_d.valid    = in_accept;
    pix_d.mask_bit = mask_bit_i;
    pix_d.x        = x_cur;
    pix_d.y        = y_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
      if (in_accept) begin
        x_q <= x_d;
        y_q <= y_d;
      end
    end
  end

  bmmf_line_store u_line_store (
    .clk_i   (clk_i),
    .raddr_i (x_cur),
    .wr_i    (ls_wr),
    .rdata_o (rows)
  );

  bmmf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_q),
    .rows_i   (rows),
    .width_i  (width_eff),
    .height_i (height_eff),
    .wr_o     (ls_wr),
    .push_o   (push),
    .res_o    (res)
  );

  assign pop = !fifo_stat.empty && !out_stall_i;

  bmmf_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fifo_stat)
  );

  assign out_valid_o    = !fifo_stat.empty;
  assign out_x_o        = head.x;
  assign out_y_o        = head.y;
  assign filtered_bit_o = head.filtered_bit;

  // Queue never overflows: queued results plus the one in flight fit
  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, inflight <= (FifoCntW + 1)'(FifoDepth), "result queue overflow")
  // Every accepted pixel reaches the window stage next cycle
  `ASSERT_NEXT(a_accept_advances, clk_i, rst_ni, in_accept, pix_q.valid, "accepted pixel lost")
  // A result is pushed only for a pixel in the window stage
  `ASSERT_IMPLIES(a_push_has_pixel, clk_i, rst_ni, push, pix_q.valid && ls_wr.we, "result without pixel")
  // Hold a stalled result until it is taken
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(head), "held result changed")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming 3x3 majority filter on binary masks.
`timescale 1ns / 1ps

module tb_top;
  import bmmf_pkg::*;

  localparam int RandomPixels = 280;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 1000000;
  localparam int HoldEvery    = 150;
  localparam int HoldCycles   = 40;
  localparam int MaxPrinted   = 30;

  // Receiver stall behavior
  typedef enum int {RecvFlow, RecvHalf, RecvBusy} recv_mode_e;

  // One mask pixel on its way to the block
  typedef struct packed {
    logic mask;
    logic fstart;
  } mask_px_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  cfg_idx_e          cfg_idx_i     = CfgFrameWidth;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              mask_bit_i    = 1'b0;
  logic              frame_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [XW-1:0]     out_x_o;
  logic [YW-1:0]     out_y_o;
  logic              filtered_bit_o;

  binary_mask_majority_filter_3x3_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mask_bit_i     (mask_bit_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .filtered_bit_o (filtered_bit_o)
  );

  // Pixels waiting for the driver and filtered pixels still owed by the block
  mask_px_t    pixel_feed[$];
  res_t        filtered_due[$];

  // Shadow of the filter: registers, line stores, window and position
  logic [CfgWW-1:0] frame_w_reg = 12'd640;
  logic [CfgHW-1:0] frame_h_reg = 13'd480;
  bit          line_older [MaxWidth];
  bit          line_newer [MaxWidth];
  logic [8:0]  win_bits   = '0;
  int unsigned col_pos    = 0;
  int unsigned row_pos    = 0;

  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_mark  = 60;
  int unsigned mode_left  = 0;
  int unsigned taken_cnt  = 0;
  recv_mode_e  recv_mode  = RecvFlow;
  mask_px_t    next_px;
  res_t        want;

  // Clock and the single reset pulse
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    begin
      if (mismatches < MaxPrinted) $display("[%0d] mismatch: %s", cycle_cnt, what);
      mismatches++;
    end
  endtask

  // Out-of-range sizes act as the nearest legal size
  function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
    begin
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    end
  endfunction

  // Advance the shadow filter by one pixel and record the result it owes
  task automatic advance_filter(input logic mask, input logic fstart);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned idx;
    int unsigned cx;
    int unsigned cy;
    res_t        r;
    begin
      w = eff_size(frame_w_reg, MaxWidth);
      h = eff_size(frame_h_reg, MaxHeight);
      if (fstart) begin
        col_pos = 0;
        row_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      idx = x % MaxWidth;
      // shift in the new column: row y at top bit, row y-2 at the bottom
      win_bits = {mask, line_newer[idx], line_older[idx], win_bits[8:3]};
      line_older[idx] = line_newer[idx];
      line_newer[idx] = mask;
      if (x >= 1 && y >= 1) begin
        cx = x - 1;
        cy = y - 1;
        r.x = cx[XW-1:0];
        r.y = cy[YW-1:0];
        if (cx == 0 || cy == 0 || cx >= w - 1 || cy >= h - 1) r.filtered_bit = 1'b0;
        else r.filtered_bit = ($countones(win_bits) > MajorityLimit);
        filtered_due.push_back(r);
      end
      if (x + 1 >= w) begin
        col_pos = 0;
        row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
      end
    end
  endtask

  // Driver: bursts of pixels from the feed with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      mask_bit_i    <= 1'b0;
      frame_start_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) advance_filter(mask_bit_i, frame_start_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          next_px = pixel_feed.pop_front();
          in_valid_i    <= 1'b1;
          mask_bit_i    <= next_px.mask;
          frame_start_i <= next_px.fstart;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random modes, plus a long hold now and then to fill the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) taken_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i && taken_cnt >= hold_mark &&
                   pixel_feed.size() >= 4) begin
        // hold while the sender still has pixels to offer
        hold_left = HoldCycles;
        hold_mark = taken_cnt + HoldEvery;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          recv_mode = recv_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(30, 200);
        end else begin
          mode_left--;
        end
        case (recv_mode)
          RecvFlow: out_stall_i <= 1'b0;
          RecvHalf: out_stall_i <= 1'($urandom_range(0, 1));
          default:  out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result transaction with the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result x=%0d y=%0d", out_x_o, out_y_o));
      end else begin
        want = filtered_due.pop_front();
        if (out_x_o !== want.x)
          flag_mismatch($sformatf("out_x %0d, want %0d", out_x_o, want.x));
        if (out_y_o !== want.y)
          flag_mismatch($sformatf("out_y %0d, want %0d", out_y_o, want.y));
        if (filtered_bit_o !== want.filtered_bit)
          flag_mismatch($sformatf("filtered_bit %b, want %b at (%0d,%0d)",
                                  filtered_bit_o, want.filtered_bit, want.x, want.y));
      end
    end
  end

  // Register write while the block is idle; the shadow copy follows it
  task automatic write_frame_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      if (idx == CfgFrameWidth) frame_w_reg = val[CfgWW-1:0];
      else frame_h_reg = val[CfgHW-1:0];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
    end
  endtask

  task automatic push_px(input logic mask, input logic fstart);
    mask_px_t px;
    begin
      px.mask   = mask;
      px.fstart = fstart;
      pixel_feed.push_back(px);
    end
  endtask

  // Hold until every pixel is taken and every result delivered, then settle
  task automatic wait_idle();
    begin
      while (pixel_feed.size() != 0 || in_valid_i || filtered_due.size() != 0)
        @(negedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
    end
  endtask

  // Raster frames with random content; a few restart mid-frame
  task automatic queue_frames(input int unsigned w, input int unsigned h,
                              input int unsigned n_px, input int unsigned density,
                              input int unsigned restart_pct);
    int unsigned i;
    int unsigned pos;
    int unsigned frame_len;
    logic        fs;
    begin
      frame_len = w * h;
      pos = 0;
      for (i = 0; i < n_px; i++) begin
        if (i == 0) begin
          fs = 1'b1;
        end else if ($urandom_range(0, 99) < restart_pct) begin
          fs  = 1'b1;
          pos = 0;
        end else begin
          fs = (pos == 0) && ($urandom_range(0, 9) != 0);
        end
        push_px($urandom_range(0, 99) < density, fs);
        pos = (pos + 1) % frame_len;
      end
    end
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] wv, input logic [CfgDataW-1:0] hv,
                           input int unsigned n_px, input int unsigned density,
                           input int unsigned restart_pct);
    begin
      write_frame_reg(CfgFrameWidth, wv);
      write_frame_reg(CfgFrameHeight, hv);
      @(negedge clk_i);
      queue_frames(eff_size(wv[CfgWW-1:0], MaxWidth), eff_size(hv[CfgHW-1:0], MaxHeight),
                   n_px, density, restart_pct);
      wait_idle();
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [19:0]         frame_bits;
    logic [CfgDataW-1:0] wv;
    logic [CfgDataW-1:0] hv;
    int unsigned         random_px;
    int unsigned         n_px;
    int unsigned         density;
    int                  i;

    frame_bits = 20'b11001_10101_01011_01110;
    random_px  = 0;
    @(posedge rst_ni);

    // Small hand-made frame: majority counts of four and five, both results
    write_frame_reg(CfgFrameWidth, 13'd5);
    write_frame_reg(CfgFrameHeight, 13'd4);
    @(negedge clk_i);
    for (i = 19; i >= 0; i--) push_px(frame_bits[i], i == 19);
    push_px(1'b1, 1'b0);
    push_px(1'b1, 1'b0);
    push_px(1'b0, 1'b1);
    wait_idle();

    // Shrink both sizes mid-frame: position past the new limits wraps
    write_frame_reg(CfgFrameWidth, 13'd8);
    write_frame_reg(CfgFrameHeight, 13'd6);
    @(negedge clk_i);
    for (i = 0; i < 19; i++) push_px(1'($urandom_range(0, 1)), i == 0);
    wait_idle();
    write_frame_reg(CfgFrameWidth, 13'd3);
    write_frame_reg(CfgFrameHeight, 13'd2);
    @(negedge clk_i);
    for (i = 0; i < 12; i++) push_px(1'($urandom_range(0, 1)), 1'b0);
    wait_idle();

    // Smallest and zero sizes
    run_phase(13'd0, 13'd0, 10, 50, 0);
    run_phase(13'd1, 13'd5, 12, 50, 0);
    run_phase(13'd6, 13'd1, 14, 50, 0);

    // Random frames, mostly small, now and then an extreme size
    while (random_px < RandomPixels) begin
      case ($urandom_range(0, 9))
        0:       wv = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'd4095;
        1:       wv = ($urandom_range(0, 1) != 0) ? 13'd2 : 13'd2048;
        default: wv = CfgDataW'($urandom_range(3, 9));
      endcase
      case ($urandom_range(0, 9))
        0:       hv = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'd8191;
        1:       hv = ($urandom_range(0, 1) != 0) ? 13'd2 : 13'd4096;
        default: hv = CfgDataW'($urandom_range(3, 7));
      endcase
      case ($urandom_range(0, 3))
        0:       density = 15;
        1:       density = 85;
        default: density = $urandom_range(40, 60);
      endcase
      n_px = $urandom_range(20, 70);
      run_phase(wv, hv, n_px, density, 5);
      random_px += n_px;
    end

    // Widest rows: register top bit dropped, value saturates
    run_phase(13'h1FFF, 13'd3, 24, 50, 0);
    // Tallest frame on narrow rows
    run_phase(13'd3, 13'h1FFF, 30, 50, 0);
    // Exact maximum sizes
    run_phase(13'd2048, 13'd4096, 40, 60, 0);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bmmf_pkg.sv
rtl/core/bmmf_line_store.sv
rtl/core/bmmf_window.sv
rtl/core/bmmf_out_fifo.sv
rtl/core/binary_mask_majority_filter_3x3_unit.sv
tb/tb_top.sv
